FILE: src/cpe_pkg.sv
// ----------------------------------------------------------------------------
// cpe_pkg
// Shared types and constants for the closest point on polygon edges block.
// ----------------------------------------------------------------------------
package cpe_pkg;

    localparam int unsigned CoordW = 31;
    localparam int unsigned DiffW  = 33;
    localparam int unsigned ProdW  = 2 * DiffW;
    localparam int unsigned FracW  = 32;

    // 0.01 unit^2 in raw^2 units, truncated
    localparam logic [63:0] ShortEdgeLimit = 64'd42949672;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [DiffW-1:0]  t_diff;
    typedef logic signed [ProdW-1:0]  t_prod;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SUB,
        ST_MAX,
        ST_MAY,
        ST_MDX,
        ST_MDY,
        ST_NUM,
        ST_CHK,
        ST_DIV,
        ST_IX,
        ST_IY,
        ST_PY,
        ST_DX,
        ST_DY,
        ST_DIST
    } t_state;

endpackage

FILE: src/cpe_mul.sv
// ----------------------------------------------------------------------------
// cpe_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module cpe_mul (
    input  logic                 i_clk,
    input  cpe_pkg::t_diff       i_a,
    input  cpe_pkg::t_diff       i_b,
    output cpe_pkg::t_prod       o_prod
);
    import cpe_pkg::*;

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= t_prod'(i_a) * t_prod'(i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: src/cpe_div.sv
// ----------------------------------------------------------------------------
// cpe_div
// Restoring divider, one quotient bit per cycle, 0.32 fraction of num/den.
// ----------------------------------------------------------------------------
module cpe_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [63:0]                   i_num,
    input  logic [63:0]                   i_den,
    output logic                          o_done,
    output logic [cpe_pkg::FracW-1:0]     o_quot
);
    import cpe_pkg::*;

    logic [64:0]      r_rem;
    logic [63:0]      r_den;
    logic [FracW-1:0] r_quot;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [64:0]      shifted;
    logic             fits;

    assign shifted = {r_rem[63:0], 1'b0};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(FracW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? (shifted - {1'b0, r_den}) : shifted;
            r_quot <= {r_quot[FracW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held more than one cycle");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");

endmodule

FILE: src/closest_point_on_polygon_edges_core.sv
// ----------------------------------------------------------------------------
// closest_point_on_polygon_edges_core
// Nearest point to a query over a run of edges, one edge per transaction.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one edge per transaction. The query
// point is taken from the first edge of a run; i_last_edge ends the run.
// Output channel: o_valid / i_stall carry the nearest point, one transaction
// per run, issued after the last edge has been worked.
// An edge that clamps to an endpoint or is short skips the divider; an
// edge that needs the interior projection also waits for it: one shared
// 33x33 multiplier runs up to eight products in turn and the restoring
// divider runs until it signals done.
// One edge is in flight at a time; o_stall is high while an edge is worked
// and while a result waits to be taken.
// A stalled result holds its value and blocks new edges until taken.
// Reset (synchronous, active low) drops any open run and pending result.
// ----------------------------------------------------------------------------
module closest_point_on_polygon_edges_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cpe_pkg::t_coord      i_query_x,
    input  cpe_pkg::t_coord      i_query_y,
    input  cpe_pkg::t_coord      i_start_x,
    input  cpe_pkg::t_coord      i_start_y,
    input  cpe_pkg::t_coord      i_end_x,
    input  cpe_pkg::t_coord      i_end_y,
    input  logic                 i_last_edge,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cpe_pkg::t_coord      o_closest_x,
    output cpe_pkg::t_coord      o_closest_y
);
    import cpe_pkg::*;

    t_state r_state, n_state;
    logic   r_in_run;
    t_coord r_qx, r_qy, r_sx, r_sy, r_ex, r_ey;
    logic   r_last;
    t_diff  r_ax, r_ay, r_dx, r_dy;
    t_prod  r_acc, r_num;
    logic [63:0] r_den, r_best_d;
    logic [FracW-1:0] r_u;
    logic signed [31:0] r_px, r_py, r_bx, r_by;
    logic   r_o_valid;
    t_coord r_ox, r_oy;

    t_diff  mul_a, mul_b;
    t_prod  prod;
    logic   div_start;
    logic   div_done;
    logic [FracW-1:0] quot;
    logic   accept;
    logic   out_take;
    logic [31:0] off;
    logic [63:0] sq_dist;
    logic   short_edge;

    assign accept   = i_valid && !o_stall;
    assign out_take = r_o_valid && !i_stall;
    assign o_stall  = (r_state != ST_IDLE) || r_o_valid;

    assign off        = 32'((prod[63:0] + 64'h8000_0000) >> 32);
    assign sq_dist    = r_acc[63:0] + prod[63:0];
    assign short_edge = r_den <= ShortEdgeLimit;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_MAX: begin mul_a = r_ax; mul_b = r_ax; end
            ST_MAY: begin mul_a = r_ay; mul_b = r_ay; end
            ST_MDX: begin mul_a = r_dx; mul_b = r_ax; end
            ST_MDY: begin mul_a = r_dy; mul_b = r_ay; end
            ST_IX: begin
                mul_a = t_diff'({1'b0, r_u});
                mul_b = r_ax[DiffW-1] ? -r_ax : r_ax;
            end
            ST_IY: begin
                mul_a = t_diff'({1'b0, r_u});
                mul_b = r_ay[DiffW-1] ? -r_ay : r_ay;
            end
            ST_DX: begin
                mul_a = t_diff'(r_px) - t_diff'(r_qx);
                mul_b = mul_a;
            end
            ST_DY: begin
                mul_a = t_diff'(r_py) - t_diff'(r_qy);
                mul_b = mul_a;
            end
            default: ;
        endcase
    end

    cpe_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    cpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num[63:0]),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_SUB;
            ST_SUB:  n_state = ST_MAX;
            ST_MAX:  n_state = ST_MAY;
            ST_MAY:  n_state = ST_MDX;
            ST_MDX:  n_state = ST_MDY;
            ST_MDY:  n_state = ST_NUM;
            ST_NUM:  n_state = ST_CHK;
            ST_CHK: begin
                if (short_edge || r_num <= 0 || r_num >= t_prod'({2'b00, r_den})) begin
                    n_state = ST_DX;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV:  if (div_done) n_state = ST_IX;
            ST_IX:   n_state = ST_IY;
            ST_IY:   n_state = ST_PY;
            ST_PY:   n_state = ST_DX;
            ST_DX:   n_state = ST_DY;
            ST_DY:   n_state = ST_DIST;
            ST_DIST: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_in_run  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_take) r_o_valid <= 1'b0;
            if (accept) r_in_run <= 1'b1;
            if (r_state == ST_DIST && r_last) begin
                r_in_run  <= 1'b0;
                r_o_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sx   <= i_start_x;
            r_sy   <= i_start_y;
            r_ex   <= i_end_x;
            r_ey   <= i_end_y;
            r_last <= i_last_edge;
            if (!r_in_run) begin
                r_qx     <= i_query_x;
                r_qy     <= i_query_y;
                r_best_d <= '1;
            end
        end
        unique case (r_state)
            ST_SUB: begin
                r_ax <= t_diff'(r_ex) - t_diff'(r_sx);
                r_ay <= t_diff'(r_ey) - t_diff'(r_sy);
                r_dx <= t_diff'(r_qx) - t_diff'(r_sx);
                r_dy <= t_diff'(r_qy) - t_diff'(r_sy);
            end
            ST_MAY: r_acc <= prod;
            ST_MDX: r_den <= 64'(r_acc + prod);
            ST_MDY: r_acc <= prod;
            ST_NUM: r_num <= r_acc + prod;
            ST_CHK: begin
                if (short_edge || r_num <= 0) begin
                    r_px <= 32'(r_sx);
                    r_py <= 32'(r_sy);
                end else begin
                    r_px <= 32'(r_ex);
                    r_py <= 32'(r_ey);
                end
            end
            ST_DIV: if (div_done) r_u <= quot;
            ST_IY:  r_px <= r_ax[DiffW-1] ? 32'(r_sx) - off : 32'(r_sx) + off;
            ST_PY:  r_py <= r_ay[DiffW-1] ? 32'(r_sy) - off : 32'(r_sy) + off;
            ST_DY:  r_acc <= prod;
            ST_DIST: begin
                if (sq_dist < r_best_d) begin
                    r_best_d <= sq_dist;
                    r_bx     <= r_px;
                    r_by     <= r_py;
                end
                if (r_last) begin
                    r_ox <= (sq_dist < r_best_d) ? t_coord'(r_px) : t_coord'(r_bx);
                    r_oy <= (sq_dist < r_best_d) ? t_coord'(r_py) : t_coord'(r_by);
                end
            end
            default: ;
        endcase
    end

    assign o_valid     = r_o_valid;
    assign o_closest_x = r_ox;
    assign o_closest_y = r_oy;

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_SUB) else $error("edge taken outside idle");
    a_result_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIST && r_last) |=> (o_valid && !r_in_run))
        else $error("last edge gave no result");
    a_div_from_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> r_state == ST_CHK) else $error("divider started out of turn");
    a_no_result_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIST && !r_last && !r_o_valid) |=> !o_valid)
        else $error("result on a non-last edge");

endmodule
